// File: design/bpa_pkg.sv
// ============================================================================
// bpa_pkg
// Shared types, codes and helper functions of the buddy page allocator.
// ============================================================================
package bpa_pkg;

    localparam int ORDER_W = 4;
    localparam int SUM_W   = 20;

    localparam logic [1:0] NODE_ALLOC = 2'd0;
    localparam logic [1:0] NODE_FREE  = 2'd1;
    localparam logic [1:0] NODE_SPLIT = 2'd2;

    localparam logic [1:0] STS_DONE       = 2'd0;
    localparam logic [1:0] STS_ALLOC_FAIL = 2'd1;
    localparam logic [1:0] STS_FREE_REJ   = 2'd2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_DECODE,
        S_SEEK_RD,
        S_SEEK_EV,
        S_SPLIT_L,
        S_SPLIT_R,
        S_BACK,
        S_MARK,
        S_CLIMB_RD,
        S_CLIMB_EV,
        S_CNT_START,
        S_COUNT,
        S_COUNT_END,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               func;
        logic [16:0]        request_pages;
        logic [15:0]        page_offset;
    } t_req;

    typedef struct packed {
        logic               set_up;
        logic [ORDER_W-1:0] order;
        logic [15:0]        region_pages;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  status;
        logic [14:0] base_page;
        logic [15:0] avail_pages;
    } t_result;

    function automatic logic [ORDER_W-1:0] floor_log2(input logic [15:0] v);
        logic [ORDER_W-1:0] r;
        r = '0;
        for (int i = 1; i < 16; i++) begin
            if (v[i]) begin
                r = ORDER_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [4:0] ceil_log2(input logic [16:0] n);
        logic [16:0] m;
        logic [4:0]  r;
        m = n - 17'd1;
        r = '0;
        for (int i = 0; i < 17; i++) begin
            if (m[i]) begin
                r = 5'(i + 1);
            end
        end
        if (n <= 17'd1) begin
            r = '0;
        end
        return r;
    endfunction

endpackage

// File: design/bpa_if.sv
// ============================================================================
// bpa_if
// Valid/ready channel interfaces: request, response and configuration.
// ============================================================================
interface bpa_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [16:0] request_pages;
    logic [15:0] page_offset;

    modport source (output valid, output func, output request_pages,
                    output page_offset, input ready);
    modport sink   (input valid, input func, input request_pages,
                    input page_offset, output ready);
endinterface

interface bpa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [14:0] base_page;
    logic [15:0] avail_pages;

    modport source (output valid, output status, output base_page,
                    output avail_pages, input ready);
    modport sink   (input valid, input status, input base_page,
                    input avail_pages, output ready);
endinterface

interface bpa_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] region_pages;

    modport source (output valid, output region_pages, input ready);
    modport sink   (input valid, input region_pages, output ready);
endinterface

// File: design/bpa_node_ram.sv
// ============================================================================
// bpa_node_ram
// Node state memory: one write port, two registered read ports.
// ============================================================================
module bpa_node_ram #(
    parameter int AW = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [1:0]    i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [1:0]    o_rdata_a,
    output logic [1:0]    o_rdata_b
);

    logic [1:0] mem [2**AW];
    logic [1:0] r_rdata_a;
    logic [1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata_a <= mem[i_raddr_a];
        r_rdata_b <= mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// File: design/bpa_engine.sv
// ============================================================================
// bpa_engine
// Sequencer: tree search, subtree sweeps, ancestor updates and free scan.
// ============================================================================
module bpa_engine #(
    parameter int NODE_W = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bpa_pkg::t_cfg        i_cfg,
    input  logic                 i_cfg_wr,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  bpa_pkg::t_req        i_req,
    output logic                 o_done,
    output bpa_pkg::t_result     o_result,
    input  logic                 i_rsp_free,
    output logic                 o_we,
    output logic [NODE_W-1:0]    o_waddr,
    output logic [1:0]           o_wdata,
    output logic [NODE_W-1:0]    o_raddr_a,
    output logic [NODE_W-1:0]    o_raddr_b,
    input  logic [1:0]           i_rdata_a,
    input  logic [1:0]           i_rdata_b
);

    localparam int OW = bpa_pkg::ORDER_W;
    localparam int SW = bpa_pkg::SUM_W;

    bpa_pkg::t_state r_state, n_state;

    logic              r_func,     n_func;
    logic [4:0]        r_k,        n_k;
    logic              r_nzero,    n_nzero;
    logic [15:0]       r_off,      n_off;
    logic [NODE_W-1:0] r_idx,      n_idx;
    logic [OW-1:0]     r_depth,    n_depth;
    logic [OW-1:0]     r_target,   n_target;
    logic [1:0]        r_status,   n_status;
    logic [14:0]       r_start,    n_start;
    logic [NODE_W-1:0] r_sw_base,  n_sw_base;
    logic [NODE_W-1:0] r_sw_pos,   n_sw_pos;
    logic [NODE_W-1:0] r_sw_last,  n_sw_last;
    logic [OW-1:0]     r_sw_depth, n_sw_depth;
    logic [1:0]        r_sw_val,   n_sw_val;
    logic [NODE_W-1:0] r_ci,       n_ci;
    logic [OW-1:0]     r_ci_depth, n_ci_depth;
    logic              r_cv,       n_cv;
    logic [OW-1:0]     r_cdep;
    logic [SW-1:0]     r_sum;
    logic              sum_clr;

    logic [NODE_W-1:0] tree_last;
    logic              sw_level_end;
    logic              sw_end;
    logic              k_ok;
    logic              alloc_ok;
    logic              free_ok;
    logic [OW-1:0]     lvl;
    logic [NODE_W-1:0] free_idx;
    logic [NODE_W-1:0] lvl_off;
    logic [31:0]       start_wide;
    logic [NODE_W-1:0] idx_dn;
    logic [NODE_W-1:0] idx_up;
    logic              cnt_hit;

    assign tree_last    = NODE_W'((32'd2 << i_cfg.order) - 32'd1);
    assign sw_level_end = (r_sw_pos == r_sw_last);
    assign sw_end       = sw_level_end && (r_sw_depth == i_cfg.order);
    assign k_ok         = (r_k <= {1'b0, i_cfg.order});
    assign lvl          = i_cfg.order - r_k[OW-1:0];
    assign alloc_ok     = i_cfg.set_up && r_nzero && k_ok;
    assign free_ok      = alloc_ok && (r_off < i_cfg.region_pages)
                          && ((r_off & ~(16'hFFFF << r_k)) == 16'd0)
                          && ({1'b0, r_off} < (17'd1 << i_cfg.order));
    assign free_idx     = NODE_W'((32'd1 << lvl) + (32'(r_off) >> r_k));
    assign lvl_off      = r_idx ^ (NODE_W'(1) << r_target);
    assign start_wide   = 32'(lvl_off) << r_k;
    assign idx_dn       = {r_idx[NODE_W-2:0], 1'b0};
    assign idx_up       = {1'b0, r_idx[NODE_W-1:1]};
    assign cnt_hit      = (i_rdata_a == bpa_pkg::NODE_FREE)
                          && ((r_cdep == '0) || (i_rdata_b != bpa_pkg::NODE_FREE));

    // next state and datapath
    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_k        = r_k;
        n_nzero    = r_nzero;
        n_off      = r_off;
        n_idx      = r_idx;
        n_depth    = r_depth;
        n_target   = r_target;
        n_status   = r_status;
        n_start    = r_start;
        n_sw_base  = r_sw_base;
        n_sw_pos   = r_sw_pos;
        n_sw_last  = r_sw_last;
        n_sw_depth = r_sw_depth;
        n_sw_val   = r_sw_val;
        n_ci       = r_ci;
        n_ci_depth = r_ci_depth;
        n_cv       = 1'b0;
        sum_clr    = 1'b0;

        case (r_state)
            bpa_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    n_func  = i_req.func;
                    n_k     = bpa_pkg::ceil_log2(i_req.request_pages);
                    n_nzero = (i_req.request_pages != 17'd0);
                    n_off   = i_req.page_offset;
                    n_start = '0;
                    n_state = bpa_pkg::S_DECODE;
                end
            end
            bpa_pkg::S_CLEAR, bpa_pkg::S_MARK: begin
                if (!i_cfg.set_up || sw_end) begin
                    n_state = (r_state == bpa_pkg::S_CLEAR) ? bpa_pkg::S_IDLE
                                                            : bpa_pkg::S_CLIMB_RD;
                end else if (sw_level_end) begin
                    n_sw_base  = {r_sw_base[NODE_W-2:0], 1'b0};
                    n_sw_last  = {r_sw_last[NODE_W-2:0], 1'b1};
                    n_sw_pos   = '0;
                    n_sw_depth = r_sw_depth + OW'(1);
                end else begin
                    n_sw_pos = r_sw_pos + NODE_W'(1);
                end
            end
            bpa_pkg::S_DECODE: begin
                if (r_func == bpa_pkg::FUNC_ALLOC) begin
                    if (alloc_ok) begin
                        n_target = lvl;
                        n_idx    = NODE_W'(1);
                        n_depth  = '0;
                        n_state  = bpa_pkg::S_SEEK_RD;
                    end else begin
                        n_status = bpa_pkg::STS_ALLOC_FAIL;
                        n_state  = bpa_pkg::S_CNT_START;
                    end
                end else begin
                    if (free_ok) begin
                        n_status   = bpa_pkg::STS_DONE;
                        n_idx      = free_idx;
                        n_depth    = lvl;
                        n_sw_base  = free_idx;
                        n_sw_pos   = '0;
                        n_sw_last  = '0;
                        n_sw_depth = lvl;
                        n_sw_val   = bpa_pkg::NODE_FREE;
                        n_state    = bpa_pkg::S_MARK;
                    end else begin
                        n_status = bpa_pkg::STS_FREE_REJ;
                        n_state  = bpa_pkg::S_CNT_START;
                    end
                end
            end
            bpa_pkg::S_SEEK_RD: begin
                n_state = bpa_pkg::S_SEEK_EV;
            end
            bpa_pkg::S_SEEK_EV: begin
                if (i_rdata_a == bpa_pkg::NODE_ALLOC) begin
                    n_state = bpa_pkg::S_BACK;
                end else if (r_depth == r_target) begin
                    if (i_rdata_a == bpa_pkg::NODE_FREE) begin
                        n_status   = bpa_pkg::STS_DONE;
                        n_start    = start_wide[14:0];
                        n_sw_base  = r_idx;
                        n_sw_pos   = '0;
                        n_sw_last  = '0;
                        n_sw_depth = r_depth;
                        n_sw_val   = bpa_pkg::NODE_ALLOC;
                        n_state    = bpa_pkg::S_MARK;
                    end else begin
                        n_state = bpa_pkg::S_BACK;
                    end
                end else if (i_rdata_a == bpa_pkg::NODE_FREE) begin
                    n_state = bpa_pkg::S_SPLIT_L;
                end else begin
                    n_idx   = idx_dn;
                    n_depth = r_depth + OW'(1);
                    n_state = bpa_pkg::S_SEEK_RD;
                end
            end
            bpa_pkg::S_SPLIT_L: begin
                n_state = bpa_pkg::S_SPLIT_R;
            end
            bpa_pkg::S_SPLIT_R: begin
                n_idx   = idx_dn;
                n_depth = r_depth + OW'(1);
                n_state = bpa_pkg::S_SEEK_RD;
            end
            bpa_pkg::S_BACK: begin
                if (r_idx == NODE_W'(1)) begin
                    n_status = bpa_pkg::STS_ALLOC_FAIL;
                    n_state  = bpa_pkg::S_CNT_START;
                end else if (r_idx[0]) begin
                    n_idx   = idx_up;
                    n_depth = r_depth - OW'(1);
                end else begin
                    n_idx   = r_idx | NODE_W'(1);
                    n_state = bpa_pkg::S_SEEK_RD;
                end
            end
            bpa_pkg::S_CLIMB_RD: begin
                n_state = (r_idx == NODE_W'(1)) ? bpa_pkg::S_CNT_START
                                                : bpa_pkg::S_CLIMB_EV;
            end
            bpa_pkg::S_CLIMB_EV: begin
                n_idx   = idx_up;
                n_depth = r_depth - OW'(1);
                n_state = bpa_pkg::S_CLIMB_RD;
                if (r_func == bpa_pkg::FUNC_FREE && i_rdata_a == bpa_pkg::NODE_FREE
                    && i_rdata_b == bpa_pkg::NODE_FREE) begin
                    n_sw_base  = idx_up;
                    n_sw_pos   = '0;
                    n_sw_last  = '0;
                    n_sw_depth = r_depth - OW'(1);
                    n_sw_val   = bpa_pkg::NODE_FREE;
                    n_state    = bpa_pkg::S_MARK;
                end
            end
            bpa_pkg::S_CNT_START: begin
                sum_clr    = 1'b1;
                n_ci       = NODE_W'(1);
                n_ci_depth = '0;
                n_state    = i_cfg.set_up ? bpa_pkg::S_COUNT : bpa_pkg::S_DONE;
            end
            bpa_pkg::S_COUNT: begin
                n_cv = 1'b1;
                n_ci = r_ci + NODE_W'(1);
                if ((r_ci & (r_ci + NODE_W'(1))) == '0) begin
                    n_ci_depth = r_ci_depth + OW'(1);
                end
                if (r_ci == tree_last) begin
                    n_state = bpa_pkg::S_COUNT_END;
                end
            end
            bpa_pkg::S_COUNT_END: begin
                n_state = bpa_pkg::S_DONE;
            end
            bpa_pkg::S_DONE: begin
                if (i_rsp_free) begin
                    n_state = bpa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bpa_pkg::S_IDLE;
            end
        endcase

        if (i_cfg_wr) begin
            n_state    = bpa_pkg::S_CLEAR;
            n_sw_base  = NODE_W'(1);
            n_sw_pos   = '0;
            n_sw_last  = '0;
            n_sw_depth = '0;
            n_sw_val   = bpa_pkg::NODE_FREE;
        end
    end

    // memory and handshake outputs
    always_comb begin
        o_we        = 1'b0;
        o_waddr     = r_sw_base + r_sw_pos;
        o_wdata     = r_sw_val;
        o_raddr_a   = r_idx;
        o_raddr_b   = r_idx;
        o_req_ready = 1'b0;
        o_done      = 1'b0;

        case (r_state)
            bpa_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
            end
            bpa_pkg::S_CLEAR, bpa_pkg::S_MARK: begin
                o_we = i_cfg.set_up;
            end
            bpa_pkg::S_SEEK_EV: begin
                o_waddr = r_idx;
                o_wdata = bpa_pkg::NODE_SPLIT;
                o_we    = (r_depth != r_target) && (i_rdata_a == bpa_pkg::NODE_FREE);
            end
            bpa_pkg::S_SPLIT_L: begin
                o_we    = 1'b1;
                o_waddr = idx_dn;
                o_wdata = bpa_pkg::NODE_FREE;
            end
            bpa_pkg::S_SPLIT_R: begin
                o_we    = 1'b1;
                o_waddr = idx_dn | NODE_W'(1);
                o_wdata = bpa_pkg::NODE_FREE;
            end
            bpa_pkg::S_CLIMB_RD: begin
                o_raddr_a = {r_idx[NODE_W-1:1], 1'b0};
                o_raddr_b = {r_idx[NODE_W-1:1], 1'b1};
            end
            bpa_pkg::S_CLIMB_EV: begin
                o_waddr = idx_up;
                if (r_func == bpa_pkg::FUNC_ALLOC) begin
                    o_we    = 1'b1;
                    o_wdata = (i_rdata_a == bpa_pkg::NODE_ALLOC
                               && i_rdata_b == bpa_pkg::NODE_ALLOC)
                              ? bpa_pkg::NODE_ALLOC : bpa_pkg::NODE_SPLIT;
                end else if (!(i_rdata_a == bpa_pkg::NODE_FREE
                               && i_rdata_b == bpa_pkg::NODE_FREE)) begin
                    o_we    = 1'b1;
                    o_wdata = bpa_pkg::NODE_SPLIT;
                end
            end
            bpa_pkg::S_COUNT: begin
                o_raddr_a = r_ci;
                o_raddr_b = {1'b0, r_ci[NODE_W-1:1]};
            end
            bpa_pkg::S_DONE: begin
                o_done = 1'b1;
            end
            default: begin
                o_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpa_pkg::S_IDLE;
            r_cv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cv    <= n_cv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_k        <= n_k;
        r_nzero    <= n_nzero;
        r_off      <= n_off;
        r_idx      <= n_idx;
        r_depth    <= n_depth;
        r_target   <= n_target;
        r_status   <= n_status;
        r_start    <= n_start;
        r_sw_base  <= n_sw_base;
        r_sw_pos   <= n_sw_pos;
        r_sw_last  <= n_sw_last;
        r_sw_depth <= n_sw_depth;
        r_sw_val   <= n_sw_val;
        r_ci       <= n_ci;
        r_ci_depth <= n_ci_depth;
        r_cdep     <= r_ci_depth;
        if (sum_clr) begin
            r_sum <= '0;
        end else if (r_cv && cnt_hit) begin
            r_sum <= r_sum + SW'(32'd1 << (i_cfg.order - r_cdep));
        end
    end

    assign o_result.status      = r_status;
    assign o_result.base_page   = r_start;
    assign o_result.avail_pages = r_sum[15:0];

endmodule

// File: design/buddy_page_allocator_tree_core.sv
// ============================================================================
// buddy_page_allocator_tree_core
// Buddy page allocator over a binary tree of node states held in memory.
// ============================================================================
// One operation at a time. An operation is decoded; then an alloc runs a
// leftmost depth-first search of the tree, the nodes of a block's subtree
// are written in turn when it is marked (alloc, free and every merge), each
// ancestor is updated, and a free-page scan runs through all active nodes.
// The scan and the subtree sweeps dominate; all run through the single
// write port and two read ports of the node memory. A region_pages write
// starts a clearing pass during which no request is taken. A finished
// result waits in an output register while the next request is accepted.
// ============================================================================
module buddy_page_allocator_tree_core #(
    parameter int TOP_ORDER = 15
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bpa_req_if.sink    i_req,
    bpa_rsp_if.source  o_rsp,
    bpa_cfg_if.sink    i_cfg
);

    localparam int OrdCap = (TOP_ORDER < 15) ? TOP_ORDER : 15;
    localparam int NodeW  = OrdCap + 1;
    localparam int OW     = bpa_pkg::ORDER_W;

    bpa_pkg::t_cfg    r_cfg;
    bpa_pkg::t_req    req;
    bpa_pkg::t_result result;
    bpa_pkg::t_result r_rsp;
    logic             r_rsp_valid;
    logic             cfg_wr;
    logic             eng_done;
    logic             rsp_free;
    logic [OW-1:0]    flog;

    logic             we;
    logic [NodeW-1:0] waddr;
    logic [1:0]       wdata;
    logic [NodeW-1:0] raddr_a;
    logic [NodeW-1:0] raddr_b;
    logic [1:0]       rdata_a;
    logic [1:0]       rdata_b;

    assign i_cfg.ready       = 1'b1;
    assign cfg_wr            = i_cfg.valid;
    assign flog              = bpa_pkg::floor_log2(i_cfg.region_pages);
    assign req.func          = i_req.func;
    assign req.request_pages = i_req.request_pages;
    assign req.page_offset   = i_req.page_offset;
    assign rsp_free          = !r_rsp_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            r_cfg.region_pages <= i_cfg.region_pages;
            r_cfg.set_up       <= (i_cfg.region_pages != 16'd0);
            r_cfg.order        <= (32'(flog) > OrdCap) ? OW'(OrdCap) : flog;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (eng_done && rsp_free) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_done && rsp_free) begin
            r_rsp <= result;
        end
    end

    assign o_rsp.valid       = r_rsp_valid;
    assign o_rsp.status      = r_rsp.status;
    assign o_rsp.base_page   = r_rsp.base_page;
    assign o_rsp.avail_pages = r_rsp.avail_pages;

    bpa_node_ram #(
        .AW (NodeW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    bpa_engine #(
        .NODE_W (NodeW)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cfg_wr    (cfg_wr),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_req       (req),
        .o_done      (eng_done),
        .o_result    (result),
        .i_rsp_free  (rsp_free),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr_a   (raddr_a),
        .o_raddr_b   (raddr_b),
        .i_rdata_a   (rdata_a),
        .i_rdata_b   (rdata_b)
    );

endmodule
